// ===== hw/rtl/rtch_pkg.sv =====
// ============================================================================
// rtch_pkg
// Shared widths, command codes and helpers for the closest-hit ray unit.
// ============================================================================
package rtch_pkg;

    // Chunk width of the pipelined multipliers (one partial product a stage)
    localparam int MUL_CH  = 24;

    // Fixed-point layout
    localparam int FRAC    = 16;
    localparam int T_W     = 31;
    localparam int W_COORD = 32;
    localparam int W_DIFF  = 33;
    localparam int W_NORM  = 51;
    localparam int W_SUM   = 86;
    localparam int W_MAG   = 85;
    localparam int W_IDX   = 10;
    localparam int W_CNT   = 11;
    localparam int APB_AW  = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RAY  = 1'b1;

    localparam int NUM_CORNERS = 3;

    localparam logic [APB_AW-1:0] ADDR_TRI_COUNT = 2'd0;

    // Stages taken by an rtch_mul of the given operand widths
    function automatic int mul_lat(input int wa, input int wb);
        return ((wa + MUL_CH - 1) / MUL_CH) * ((wb + MUL_CH - 1) / MUL_CH);
    endfunction

endpackage

// ===== hw/rtl/ray_triangle_closest_hit.sv =====
// ============================================================================
// ray_triangle_closest_hit
// Closest-hit search of one ray over a store of triangles, plane-then-edge test.
// ============================================================================
// Usage:
//   Command channel: an item transfers on a rising edge with start high and
//   busy low. Load items (cmd 0) write one corner into the triangle store and
//   finish in that cycle; they produce no result. A ray item (cmd 1) raises
//   busy and sweeps triangles 0 to count-1, one triangle issued per cycle into
//   a pipeline (corner read, normal, plane dot products, 31-stage divider,
//   point, a cross and a dot per edge, closest-hit select).
//   Result: o_done is high for exactly one cycle with the hit fields; busy
//   drops in that same cycle, so the next item may transfer at its end.
//   Rays are handled one at a time.
//   The receiver cannot stall: o_done is not held; the hit fields stay until the next ray transfers.
//   Configuration: triangle_count at byte address 0 over the APB port.
//   The user must write it only while busy is low; the block does not check.
//   Reset: i_rst_n clears control state and triangle_count; the triangle
//   store keeps whatever it holds and is undefined until loaded.
// ============================================================================
module ray_triangle_closest_hit #(
    parameter int MAX_TRIANGLES = 1024,
    parameter int EPSILON_Q     = 66
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cmd,
    input  logic [rtch_pkg::W_IDX-1:0]        i_tri_index,
    input  logic [1:0]                        i_corner,
    input  logic signed [31:0]                i_pos_x,
    input  logic signed [31:0]                i_pos_y,
    input  logic signed [31:0]                i_pos_z,
    input  logic signed [31:0]                i_dir_x,
    input  logic signed [31:0]                i_dir_y,
    input  logic signed [31:0]                i_dir_z,
    output logic                              o_done,
    output logic                              o_hit,
    output logic [rtch_pkg::W_IDX-1:0]        o_hit_index,
    output logic [rtch_pkg::T_W-1:0]          o_hit_distance,
    output logic signed [31:0]                o_point_x,
    output logic signed [31:0]                o_point_y,
    output logic signed [31:0]                o_point_z,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rtch_pkg::APB_AW-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int AW   = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int CW   = $clog2(MAX_TRIANGLES + 1);
    localparam int WC   = rtch_pkg::W_COORD;
    localparam int WE   = rtch_pkg::W_DIFF;
    localparam int WNM  = rtch_pkg::W_NORM;
    localparam int WS   = rtch_pkg::W_SUM;
    localparam int WM   = rtch_pkg::W_MAG;
    localparam int TW   = rtch_pkg::T_W;
    localparam int FR   = rtch_pkg::FRAC;
    localparam int L1   = rtch_pkg::mul_lat(WE, WE);
    localparam int L2   = rtch_pkg::mul_lat(WNM, WE);
    localparam int L3   = rtch_pkg::mul_lat(WC, WC);
    localparam int L4   = rtch_pkg::mul_lat(WE, WE);
    localparam int L5   = rtch_pkg::mul_lat(WNM, WNM);
    localparam int LDIV = TW;
    localparam int WPE  = 2 * WE;
    localparam int WPD  = WNM + WE;
    localparam int WPT  = 2 * WC;
    localparam int WPC  = 2 * WNM;
    localparam int WDOT = WPC + 2;

    typedef struct packed {
        logic                                 tv;
        logic                                 last;
        logic                                 ok;
        logic [rtch_pkg::W_IDX-1:0]           idx;
        logic [2:0][2:0][31:0]                v;
        logic [2:0][rtch_pkg::W_NORM-1:0]     n;
        logic [rtch_pkg::T_W-1:0]             t;
        logic [2:0][31:0]                     p;
    } t_tri;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [rtch_pkg::W_CNT-1:0] r_count;
    logic                       cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr == rtch_pkg::ADDR_TRI_COUNT) ? 32'(r_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (cfg_wr) begin
            r_count <= pwdata[rtch_pkg::W_CNT-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Command transfer and triangle issue
    // ------------------------------------------------------------------
    logic                   r_busy;
    logic                   r_issuing;
    logic [CW-1:0]          r_issue;
    logic [CW-1:0]          r_ray_n;
    logic signed [31:0]     r_org [3];
    logic signed [31:0]     r_dir [3];
    logic                   cmd_xfer;
    logic                   ray_xfer;
    logic                   load_xfer;
    logic                   tok_tv;
    logic                   tok_last;
    logic [CW-1:0]          ray_n;

    assign cmd_xfer  = start && !r_busy;
    assign ray_xfer  = cmd_xfer && (i_cmd == rtch_pkg::CMD_RAY);
    assign load_xfer = cmd_xfer && (i_cmd == rtch_pkg::CMD_LOAD)
                       && (32'(i_corner) < rtch_pkg::NUM_CORNERS)
                       && (32'(i_tri_index) < MAX_TRIANGLES);
    assign ray_n     = (32'(r_count) > MAX_TRIANGLES) ? CW'(MAX_TRIANGLES) : CW'(r_count);
    assign tok_tv    = r_issuing && (r_issue < r_ray_n);
    assign tok_last  = r_issuing && ((CW+1)'(r_issue) + 1'b1 >= (CW+1)'(r_ray_n));

    always_ff @(posedge i_clk) begin
        if (ray_xfer) begin
            r_org[0] <= i_pos_x;
            r_org[1] <= i_pos_y;
            r_org[2] <= i_pos_z;
            r_dir[0] <= i_dir_x;
            r_dir[1] <= i_dir_y;
            r_dir[2] <= i_dir_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
            r_issue   <= '0;
            r_ray_n   <= '0;
        end else if (ray_xfer) begin
            r_issuing <= 1'b1;
            r_issue   <= '0;
            r_ray_n   <= ray_n;
        end else if (r_issuing) begin
            r_issue <= r_issue + 1'b1;
            if (tok_last) begin
                r_issuing <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Triangle store: one memory per corner, {z, y, x}
    // ------------------------------------------------------------------
    logic [3*WC-1:0] r_rd [3];

    for (genvar c = 0; c < 3; c++) begin : g_store
        logic [3*WC-1:0] r_mem [MAX_TRIANGLES];

        always_ff @(posedge i_clk) begin
            if (load_xfer && (i_corner == 2'(c))) begin
                r_mem[AW'(i_tri_index)] <= {i_pos_z, i_pos_y, i_pos_x};
            end
            r_rd[c] <= r_mem[r_issue[AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control and sideband
    // ------------------------------------------------------------------
    t_tri r_s0, r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7, r_s8, r_s9;
    t_tri r_d1 [L1];
    t_tri r_d2 [L2];
    t_tri r_d4 [LDIV];
    t_tri r_d5 [L3];
    t_tri r_d7 [L4];
    t_tri r_d8 [L5];
    t_tri n_s0, n_s1, n_s2, n_s4, n_s5, n_s6, n_s9;

    // payload side registers
    logic signed [WE-1:0]   r_e1 [3];
    logic signed [WE-1:0]   r_e2 [3];
    logic signed [WS-1:0]   r_den3;
    logic signed [WS-1:0]   r_num3;
    logic [WM-1:0]          r_den4;
    logic [WM-1:0]          r_num4;
    logic signed [WE-1:0]   r_ee [3][3];
    logic signed [WE-1:0]   r_vv [3][3];
    logic signed [WNM-1:0]  r_cc [3][3];

    // multiplier results and derived values
    logic signed [WPE-1:0]  w_nprod [3][2];
    logic signed [WNM-1:0]  w_n [3];
    logic signed [WE-1:0]   w_dir33 [3];
    logic signed [WE-1:0]   w_rel [3];
    logic signed [WPD-1:0]  w_dprod [3];
    logic signed [WPD-1:0]  w_rprod [3];
    logic [TW-1:0]          w_q;
    logic signed [WPT-1:0]  w_tprod [3];
    logic signed [31:0]     w_p [3];
    logic signed [WPE-1:0]  w_eprod [3][3][2];
    logic signed [WNM-1:0]  w_c [3][3];
    logic signed [WPC-1:0]  w_cprod [3][3];
    logic signed [WDOT-1:0] w_dot [3];
    logic signed [WS-1:0]   den_abs;
    logic signed [WS-1:0]   num_abs;
    logic                   plane_ok;

    // normal: cross of the edges v1 - v0 and v2 - v0
    for (genvar k = 0; k < 3; k++) begin : g_norm
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;
        logic signed [WPE:0] diff;

        rtch_mul #(.WA(WE), .WB(WE)) u_mul_a (
            .i_clk (i_clk),
            .i_a   (r_e1[K1]),
            .i_b   (r_e2[K2]),
            .o_p   (w_nprod[k][0])
        );
        rtch_mul #(.WA(WE), .WB(WE)) u_mul_b (
            .i_clk (i_clk),
            .i_a   (r_e1[K2]),
            .i_b   (r_e2[K1]),
            .o_p   (w_nprod[k][1])
        );

        assign diff   = (WPE+1)'(w_nprod[k][0]) - (WPE+1)'(w_nprod[k][1]);
        assign w_n[k] = diff[WPE:FR];
    end

    // plane: N.dir and N.(v0 - origin)
    for (genvar k = 0; k < 3; k++) begin : g_plane
        assign w_dir33[k] = WE'(r_dir[k]);
        assign w_rel[k]   = WE'($signed(r_s2.v[0][k])) - WE'(r_org[k]);

        rtch_mul #(.WA(WNM), .WB(WE)) u_mul_den (
            .i_clk (i_clk),
            .i_a   ($signed(r_s2.n[k])),
            .i_b   (w_dir33[k]),
            .o_p   (w_dprod[k])
        );
        rtch_mul #(.WA(WNM), .WB(WE)) u_mul_num (
            .i_clk (i_clk),
            .i_a   ($signed(r_s2.n[k])),
            .i_b   (w_rel[k]),
            .o_p   (w_rprod[k])
        );
    end

    assign den_abs  = r_den3[WS-1] ? -r_den3 : r_den3;
    assign num_abs  = r_den3[WS-1] ? -r_num3 : r_num3;
    assign plane_ok = (den_abs[WM-1:0] >= (WM'(EPSILON_Q) << FR))
                      && !num_abs[WS-1] && (num_abs != '0);

    rtch_div #(.WN(WM), .WD(WM)) u_div (
        .i_clk (i_clk),
        .i_num (r_num4),
        .i_den (r_den4),
        .o_q   (w_q)
    );

    // point: origin + floor(t * dir), saturated
    for (genvar k = 0; k < 3; k++) begin : g_point
        logic signed [WPT-FR:0] psum;

        rtch_mul #(.WA(WC), .WB(WC)) u_mul_t (
            .i_clk (i_clk),
            .i_a   ($signed({1'b0, r_s5.t})),
            .i_b   (r_dir[k]),
            .o_p   (w_tprod[k])
        );

        assign psum = (WPT-FR+1)'(r_org[k])
                      + (WPT-FR+1)'($signed(w_tprod[k][WPT-1:FR]));
        always_comb begin
            if (psum > (WPT-FR+1)'(32'sh7FFF_FFFF)) begin
                w_p[k] = 32'sh7FFF_FFFF;
            end else if (psum < -(WPT-FR+1)'(33'sh0_8000_0000)) begin
                w_p[k] = 32'sh8000_0000;
            end else begin
                w_p[k] = psum[31:0];
            end
        end
    end

    // edges: (b - a) x (p - a), then N . C
    for (genvar j = 0; j < 3; j++) begin : g_edge
        for (genvar k = 0; k < 3; k++) begin : g_comp
            localparam int K1 = (k + 1) % 3;
            localparam int K2 = (k + 2) % 3;
            logic signed [WPE:0] diff;

            rtch_mul #(.WA(WE), .WB(WE)) u_mul_a (
                .i_clk (i_clk),
                .i_a   (r_ee[j][K1]),
                .i_b   (r_vv[j][K2]),
                .o_p   (w_eprod[j][k][0])
            );
            rtch_mul #(.WA(WE), .WB(WE)) u_mul_b (
                .i_clk (i_clk),
                .i_a   (r_ee[j][K2]),
                .i_b   (r_vv[j][K1]),
                .o_p   (w_eprod[j][k][1])
            );

            assign diff      = (WPE+1)'(w_eprod[j][k][0]) - (WPE+1)'(w_eprod[j][k][1]);
            assign w_c[j][k] = diff[WPE:FR];

            rtch_mul #(.WA(WNM), .WB(WNM)) u_mul_dot (
                .i_clk (i_clk),
                .i_a   ($signed(r_s8.n[k])),
                .i_b   (r_cc[j][k]),
                .o_p   (w_cprod[j][k])
            );
        end

        assign w_dot[j] = WDOT'(w_cprod[j][0]) + WDOT'(w_cprod[j][1])
                          + WDOT'(w_cprod[j][2]);
    end

    always_comb begin
        n_s0      = '0;
        n_s0.tv   = tok_tv;
        n_s0.last = tok_last;
        n_s0.idx  = rtch_pkg::W_IDX'(r_issue);

        n_s1 = r_s0;
        for (int c = 0; c < 3; c++) begin
            n_s1.v[c] = r_rd[c];
        end

        n_s2 = r_d1[L1-1];
        for (int k = 0; k < 3; k++) begin
            n_s2.n[k] = w_n[k];
        end

        n_s4    = r_s3;
        n_s4.ok = r_s3.tv && plane_ok;

        n_s5    = r_d4[LDIV-1];
        n_s5.t  = w_q;
        n_s5.ok = r_d4[LDIV-1].ok && (w_q >= TW'(EPSILON_Q));

        n_s6 = r_d5[L3-1];
        for (int k = 0; k < 3; k++) begin
            n_s6.p[k] = w_p[k];
        end

        n_s9    = r_d8[L5-1];
        n_s9.ok = r_d8[L5-1].ok && !w_dot[0][WDOT-1] && !w_dot[1][WDOT-1]
                  && !w_dot[2][WDOT-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
            r_s5 <= '0;
            r_s6 <= '0;
            r_s7 <= '0;
            r_s8 <= '0;
            r_s9 <= '0;
            for (int i = 0; i < L1; i++) r_d1[i] <= '0;
            for (int i = 0; i < L2; i++) r_d2[i] <= '0;
            for (int i = 0; i < LDIV; i++) r_d4[i] <= '0;
            for (int i = 0; i < L3; i++) r_d5[i] <= '0;
            for (int i = 0; i < L4; i++) r_d7[i] <= '0;
            for (int i = 0; i < L5; i++) r_d8[i] <= '0;
        end else begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_d1[0] <= r_s1;
            for (int i = 1; i < L1; i++) r_d1[i] <= r_d1[i-1];
            r_s2 <= n_s2;
            r_d2[0] <= r_s2;
            for (int i = 1; i < L2; i++) r_d2[i] <= r_d2[i-1];
            r_s3 <= r_d2[L2-1];
            r_s4 <= n_s4;
            r_d4[0] <= r_s4;
            for (int i = 1; i < LDIV; i++) r_d4[i] <= r_d4[i-1];
            r_s5 <= n_s5;
            r_d5[0] <= r_s5;
            for (int i = 1; i < L3; i++) r_d5[i] <= r_d5[i-1];
            r_s6 <= n_s6;
            r_s7 <= r_s6;
            r_d7[0] <= r_s7;
            for (int i = 1; i < L4; i++) r_d7[i] <= r_d7[i-1];
            r_s8 <= r_d7[L4-1];
            r_d8[0] <= r_s8;
            for (int i = 1; i < L5; i++) r_d8[i] <= r_d8[i-1];
            r_s9 <= n_s9;
        end
    end

    // payload registers alongside the sideband
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_e1[k] <= WE'($signed(r_rd[1][k*WC +: WC])) - WE'($signed(r_rd[0][k*WC +: WC]));
            r_e2[k] <= WE'($signed(r_rd[2][k*WC +: WC])) - WE'($signed(r_rd[0][k*WC +: WC]));
        end
        r_den3 <= WS'(w_dprod[0]) + WS'(w_dprod[1]) + WS'(w_dprod[2]);
        r_num3 <= WS'(w_rprod[0]) + WS'(w_rprod[1]) + WS'(w_rprod[2]);
        r_den4 <= den_abs[WM-1:0];
        r_num4 <= num_abs[WM-1:0];
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                r_ee[j][k] <= WE'($signed(r_s6.v[(j+1)%3][k])) - WE'($signed(r_s6.v[j][k]));
                r_vv[j][k] <= WE'($signed(r_s6.p[k])) - WE'($signed(r_s6.v[j][k]));
                r_cc[j][k] <= w_c[j][k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Closest-hit select and result
    // ------------------------------------------------------------------
    logic [TW-1:0]              r_best;
    logic                       r_found;
    logic [rtch_pkg::W_IDX-1:0] r_hidx;
    logic [TW-1:0]              r_ht;
    logic signed [31:0]         r_pt [3];
    logic                       r_done;
    logic                       take;
    logic                       pt_zero;
    logic                       pt_org;

    assign take    = r_s9.tv && r_s9.ok && (r_s9.t <= r_best);
    assign pt_zero = (r_s9.p[0] == '0) && (r_s9.p[1] == '0) && (r_s9.p[2] == '0);
    assign pt_org  = (r_s9.p[0] == r_org[0]) && (r_s9.p[1] == r_org[1])
                     && (r_s9.p[2] == r_org[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
            r_best  <= {TW{1'b1}};
            r_hidx  <= '0;
            r_ht    <= '0;
            for (int k = 0; k < 3; k++) r_pt[k] <= '0;
        end else begin
            r_done <= r_s9.last;
            if (r_s9.last) begin
                r_busy <= 1'b0;
            end
            if (ray_xfer) begin
                r_busy  <= 1'b1;
                r_found <= 1'b0;
                r_best  <= {TW{1'b1}};
                r_hidx  <= '0;
                r_ht    <= '0;
                for (int k = 0; k < 3; k++) r_pt[k] <= '0;
            end else if (take) begin
                // a point on zero or on the origin still tightens the bound
                r_best <= r_s9.t;
                if (!pt_zero && !pt_org) begin
                    r_found <= 1'b1;
                    r_hidx  <= r_s9.idx;
                    r_ht    <= r_s9.t;
                    for (int k = 0; k < 3; k++) r_pt[k] <= $signed(r_s9.p[k]);
                end
            end
        end
    end

    assign busy           = r_busy;
    assign o_done         = r_done;
    assign o_hit          = r_found;
    assign o_hit_index    = r_hidx;
    assign o_hit_distance = r_ht;
    assign o_point_x      = r_pt[0];
    assign o_point_y      = r_pt[1];
    assign o_point_z      = r_pt[2];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_ray_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == rtch_pkg::CMD_RAY) |=> busy)
        else $error("ray transfer did not raise busy");

    a_hit_eps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit) |-> (o_hit_distance >= TW'(EPSILON_Q)))
        else $error("hit nearer than epsilon");

endmodule

// ===== hw/rtl/rtch_mul.sv =====
// ============================================================================
// rtch_mul
// Pipelined signed multiplier: one chunk-by-chunk partial product per stage.
// ============================================================================
module rtch_mul #(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                   i_clk,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);

    localparam int CH  = rtch_pkg::MUL_CH;
    localparam int NA  = (WA + CH - 1) / CH;
    localparam int NB  = (WB + CH - 1) / CH;
    localparam int NS  = NA * NB;
    localparam int WP  = WA + WB;
    localparam int WAX = NA * CH;
    localparam int WBX = NB * CH;

    logic signed [WA-1:0] r_a   [NS];
    logic signed [WB-1:0] r_b   [NS];
    logic signed [WP-1:0] r_acc [NS];

    for (genvar s = 0; s < NS; s++) begin : g_step
        localparam int IA = s / NB;
        localparam int IB = s % NB;

        logic signed [WA-1:0]     a_in;
        logic signed [WB-1:0]     b_in;
        logic signed [WP-1:0]     acc_in;
        logic signed [WAX-1:0]    ax;
        logic signed [WBX-1:0]    bx;
        logic signed [CH:0]       ca;
        logic signed [CH:0]       cb;
        logic signed [2*CH+1:0]   pp;

        if (s == 0) begin : g_first
            assign a_in   = i_a;
            assign b_in   = i_b;
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = r_a[s-1];
            assign b_in   = r_b[s-1];
            assign acc_in = r_acc[s-1];
        end

        assign ax = WAX'(a_in);
        assign bx = WBX'(b_in);

        // only the top chunk carries the sign
        if (IA == NA - 1) begin : g_atop
            assign ca = $signed({ax[IA*CH+CH-1], ax[IA*CH +: CH]});
        end else begin : g_alow
            assign ca = $signed({1'b0, ax[IA*CH +: CH]});
        end
        if (IB == NB - 1) begin : g_btop
            assign cb = $signed({bx[IB*CH+CH-1], bx[IB*CH +: CH]});
        end else begin : g_blow
            assign cb = $signed({1'b0, bx[IB*CH +: CH]});
        end

        assign pp = ca * cb;

        always_ff @(posedge i_clk) begin
            r_a[s]   <= a_in;
            r_b[s]   <= b_in;
            r_acc[s] <= acc_in + (WP'(pp) <<< ((IA + IB) * CH));
        end
    end

    assign o_p = r_acc[NS-1];

endmodule

// ===== hw/rtl/rtch_div.sv =====
// ============================================================================
// rtch_div
// Pipelined restoring divider: q = num * 2^FRAC / den, saturated, one bit a stage.
// ============================================================================
module rtch_div #(
    parameter int WN = 85,
    parameter int WD = 85
) (
    input  logic                      i_clk,
    input  logic [WN-1:0]             i_num,
    input  logic [WD-1:0]             i_den,
    output logic [rtch_pkg::T_W-1:0]  o_q
);

    localparam int WQ = rtch_pkg::T_W;
    localparam int FR = rtch_pkg::FRAC;
    localparam int WC = ((WN + FR > WD + WQ) ? WN + FR : WD + WQ) + 1;

    logic [WC-1:0] r_rem [WQ];
    logic [WD-1:0] r_den [WQ];
    logic [WQ-1:0] r_q   [WQ];
    logic          r_sat [WQ];

    for (genvar s = 0; s < WQ; s++) begin : g_bit
        localparam int B = WQ - 1 - s;

        logic [WC-1:0] rem_in;
        logic [WD-1:0] den_in;
        logic [WQ-1:0] q_in;
        logic          sat_in;
        logic [WC-1:0] dsh;
        logic          ge;

        if (s == 0) begin : g_first
            assign rem_in = WC'(i_num) << FR;
            assign den_in = i_den;
            assign q_in   = '0;
            // quotient would need more than WQ bits
            assign sat_in = (WC'(i_num) << FR) >= (WC'(i_den) << WQ);
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign q_in   = r_q[s-1];
            assign sat_in = r_sat[s-1];
        end

        assign dsh = WC'(den_in) << B;
        assign ge  = rem_in >= dsh;

        always_ff @(posedge i_clk) begin
            r_rem[s] <= ge ? rem_in - dsh : rem_in;
            r_den[s] <= den_in;
            r_q[s]   <= q_in | (WQ'(ge) << B);
            r_sat[s] <= sat_in;
        end
    end

    assign o_q = r_sat[WQ-1] ? {WQ{1'b1}} : r_q[WQ-1];

endmodule

// ===== dv/testbench.sv =====
// ============================================================================
// testbench
// Closest-hit ray unit: loads triangles, casts rays and checks every result.
// A built-in wide-arithmetic predictor computes each ray's closest hit from its
// own copy of the triangle store and triangle_count. The stimulus is a
// directed part followed by random phases with varied idling and counts.
// ============================================================================
module testbench;

    localparam int        MAX_TRI = 1024;
    localparam int        EPS_Q   = 66;
    localparam int        U       = 65536;
    localparam longint    T_SAT   = 64'h7FFF_FFFF;

    typedef logic signed [127:0] w_t;

    typedef struct {
        logic                          cmd;
        logic [rtch_pkg::W_IDX-1:0]    idx;
        logic [1:0]                    corner;
        logic signed [31:0]            pos [3];
        logic signed [31:0]            dir [3];
    } item_t;

    typedef struct {
        logic                          hit;
        logic [rtch_pkg::W_IDX-1:0]    idx;
        logic [rtch_pkg::T_W-1:0]      dist_q;
        logic signed [31:0]            pt [3];
    } hit_t;

    logic i_clk, i_rst_n, start, busy;
    logic i_cmd;
    logic [rtch_pkg::W_IDX-1:0] i_tri_index;
    logic [1:0] i_corner;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z, i_dir_x, i_dir_y, i_dir_z;
    logic o_done, o_hit;
    logic [rtch_pkg::W_IDX-1:0] o_hit_index;
    logic [rtch_pkg::T_W-1:0] o_hit_distance;
    logic signed [31:0] o_point_x, o_point_y, o_point_z;
    logic psel, penable, pwrite, pready;
    logic [rtch_pkg::APB_AW-1:0] paddr;
    logic [31:0] pwdata, prdata;

    ray_triangle_closest_hit uut (.*);

    item_t                      cmd_queue [$];
    hit_t                       pending_hits [$];
    logic signed [31:0]         corner_mem [0:3*MAX_TRI-1][0:2];
    logic [rtch_pkg::W_CNT-1:0] tri_count;
    longint                     centre [0:MAX_TRI-1][0:2];
    int                         idle_pct;
    bit                         taken;
    int                         errors, n_loads, n_rays, n_hits;
    item_t                      nxt;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic void cross_q16(input w_t a [3], input w_t b [3], output w_t c [3]);
        c[0] = w_t'(signed'((a[1]*b[2] - a[2]*b[1]) >>> 16) & {64'd0, 64'hFFFF_FFFF_FFFF_FFFF});
        c[1] = w_t'(signed'((a[2]*b[0] - a[0]*b[2]) >>> 16) & {64'd0, 64'hFFFF_FFFF_FFFF_FFFF});
        c[2] = w_t'(signed'((a[0]*b[1] - a[1]*b[0]) >>> 16) & {64'd0, 64'hFFFF_FFFF_FFFF_FFFF});
        // sign-extend the 64-bit floor back to full width
        for (int k = 0; k < 3; k++) c[k] = w_t'($signed(c[k][63:0]));
    endfunction

    function automatic w_t dot3(input w_t a [3], input w_t b [3]);
        return a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
    endfunction

    function automatic bit edge_ok(input w_t n [3], input w_t a [3], input w_t b [3],
                                   input w_t p [3]);
        w_t e [3];
        w_t v [3];
        w_t c [3];
        for (int k = 0; k < 3; k++) begin
            e[k] = b[k] - a[k];
            v[k] = p[k] - a[k];
        end
        cross_q16(e, v, c);
        return dot3(n, c) >= 0;
    endfunction

    function automatic hit_t trace_ray(input item_t it);
        hit_t r;
        w_t o [3];
        w_t d [3];
        w_t v0 [3];
        w_t v1 [3];
        w_t v2 [3];
        w_t e1 [3];
        w_t e2 [3];
        w_t rel [3];
        w_t n [3];
        w_t p [3];
        w_t den, num, q, t, best;
        int cnt;
        r.hit = 0; r.idx = '0; r.dist_q = '0;
        for (int k = 0; k < 3; k++) begin
            r.pt[k] = '0;
            o[k] = it.pos[k];
            d[k] = it.dir[k];
        end
        best = T_SAT;
        cnt = (tri_count > MAX_TRI) ? MAX_TRI : int'(tri_count);
        for (int i = 0; i < cnt; i++) begin
            for (int k = 0; k < 3; k++) begin
                v0[k] = corner_mem[3*i][k];
                v1[k] = corner_mem[3*i+1][k];
                v2[k] = corner_mem[3*i+2][k];
                e1[k] = v1[k] - v0[k];
                e2[k] = v2[k] - v0[k];
                rel[k] = v0[k] - o[k];
            end
            cross_q16(e1, e2, n);
            den = dot3(n, d);
            num = dot3(n, rel);
            if (den < 0) begin
                den = -den;
                num = -num;
            end
            if (den < w_t'(EPS_Q) * U) continue;
            if (num <= 0) continue;
            q = (num <<< 16) / den;
            t = (q > T_SAT) ? T_SAT : q;
            if (t < EPS_Q) continue;
            if (t > best) continue;
            for (int k = 0; k < 3; k++) begin
                p[k] = o[k] + ((t * d[k]) >>> 16);
                if (p[k] > 64'sd2147483647) p[k] = 64'sd2147483647;
                if (p[k] < -64'sd2147483648) p[k] = -64'sd2147483648;
            end
            if (!edge_ok(n, v0, v1, p) || !edge_ok(n, v1, v2, p) || !edge_ok(n, v2, v0, p))
                continue;
            best = t;
            // a point at zero or at the origin keeps its t but is dropped
            if ((p[0] == 0 && p[1] == 0 && p[2] == 0) ||
                (p[0] == o[0] && p[1] == o[1] && p[2] == o[2]))
                continue;
            r.hit = 1;
            r.idx = i[rtch_pkg::W_IDX-1:0];
            r.dist_q = t[rtch_pkg::T_W-1:0];
            for (int k = 0; k < 3; k++) r.pt[k] = p[k][31:0];
        end
        return r;
    endfunction

    // ---------------- driver ----------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !taken) begin
            // hold until the transfer happens
        end else if (cmd_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
            nxt = cmd_queue.pop_front();
            i_cmd <= nxt.cmd;
            i_tri_index <= nxt.idx;
            i_corner <= nxt.corner;
            i_pos_x <= nxt.pos[0]; i_pos_y <= nxt.pos[1]; i_pos_z <= nxt.pos[2];
            i_dir_x <= nxt.dir[0]; i_dir_y <= nxt.dir[1]; i_dir_z <= nxt.dir[2];
            start <= 1'b1;
        end else begin
            start <= 1'b0;
        end
    end

    // ---------------- monitor ----------------
    task automatic report(input string field, input longint got, input longint want);
        errors++;
        $display("MISMATCH %s: got %0h, expected %0h", field, got, want);
    endtask

    always @(posedge i_clk) begin
        hit_t e;
        item_t it;
        taken = 0;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_hits.size() == 0) begin
                    report("unexpected result", 1, 0);
                end else begin
                    e = pending_hits.pop_front();
                    if (o_hit !== e.hit) report("hit", o_hit, e.hit);
                    if (o_hit_index !== e.idx) report("hit_index", o_hit_index, e.idx);
                    if (o_hit_distance !== e.dist_q)
                        report("hit_distance", o_hit_distance, e.dist_q);
                    if (o_point_x !== e.pt[0]) report("point_x", o_point_x, e.pt[0]);
                    if (o_point_y !== e.pt[1]) report("point_y", o_point_y, e.pt[1]);
                    if (o_point_z !== e.pt[2]) report("point_z", o_point_z, e.pt[2]);
                    if (e.hit) n_hits++;
                end
            end
            if (start && !busy) begin
                taken = 1;
                it.cmd = i_cmd; it.idx = i_tri_index; it.corner = i_corner;
                it.pos[0] = i_pos_x; it.pos[1] = i_pos_y; it.pos[2] = i_pos_z;
                it.dir[0] = i_dir_x; it.dir[1] = i_dir_y; it.dir[2] = i_dir_z;
                if (it.cmd == rtch_pkg::CMD_LOAD) begin
                    n_loads++;
                    if (it.corner < rtch_pkg::NUM_CORNERS)
                        for (int k = 0; k < 3; k++)
                            corner_mem[3*it.idx + it.corner][k] = it.pos[k];
                end else begin
                    n_rays++;
                    pending_hits.insert(pending_hits.size(), trace_ray(it));
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic int rnd_span(input int r);
        return int'($urandom_range(0, 2*r)) - r;
    endfunction

    task automatic push_load(input int idx, input int c, input int x, input int y, input int z);
        item_t it;
        it.cmd = rtch_pkg::CMD_LOAD; it.idx = idx[rtch_pkg::W_IDX-1:0]; it.corner = c[1:0];
        it.pos[0] = x; it.pos[1] = y; it.pos[2] = z;
        for (int k = 0; k < 3; k++) it.dir[k] = $urandom;
        cmd_queue.insert(cmd_queue.size(), it);
    endtask

    task automatic push_ray(input int ox, input int oy, input int oz,
                            input int dx, input int dy, input int dz);
        item_t it;
        it.cmd = rtch_pkg::CMD_RAY;
        it.idx = rtch_pkg::W_IDX'($urandom);
        it.corner = 2'($urandom);
        it.pos[0] = ox; it.pos[1] = oy; it.pos[2] = oz;
        it.dir[0] = dx; it.dir[1] = dy; it.dir[2] = dz;
        cmd_queue.insert(cmd_queue.size(), it);
    endtask

    task automatic add_triangle(input int idx, input bit noisy);
        int cx, cy, cz, v [3][3];
        cx = rnd_span(50*U); cy = rnd_span(50*U); cz = rnd_span(50*U);
        for (int c = 0; c < 3; c++) begin
            if (noisy) begin
                v[c][0] = $urandom; v[c][1] = $urandom; v[c][2] = $urandom;
            end else begin
                v[c][0] = cx + rnd_span(20*U);
                v[c][1] = cy + rnd_span(20*U);
                v[c][2] = cz + rnd_span(20*U);
            end
            push_load(idx, c, v[c][0], v[c][1], v[c][2]);
        end
        for (int k = 0; k < 3; k++)
            centre[idx][k] = (longint'(v[0][k]) + v[1][k] + v[2][k]) / 3;
    endtask

    task automatic add_ray(input int target, input bit noisy);
        longint o [3];
        int s;
        if (noisy) begin
            push_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            s = $urandom_range(0, 4);
            for (int k = 0; k < 3; k++) o[k] = rnd_span(60*U);
            push_ray(int'(o[0]), int'(o[1]), int'(o[2]),
                     int'((centre[target][0] - o[0]) >>> s),
                     int'((centre[target][1] - o[1]) >>> s),
                     int'((centre[target][2] - o[2]) >>> s));
        end
    endtask

    task automatic write_count(input int val);
        while (cmd_queue.size() != 0 || pending_hits.size() != 0 || start || busy)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1; pwrite = 1; penable = 0; paddr = rtch_pkg::ADDR_TRI_COUNT; pwdata = val;
        @(negedge i_clk);
        penable = 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tri_count = val[rtch_pkg::W_CNT-1:0];
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    initial begin
        int cnt;
        int phase_idle [4];
        phase_idle = '{0, 54, 8, 54};
        i_rst_n = 0; start = 0; i_cmd = rtch_pkg::CMD_LOAD; i_tri_index = '0; i_corner = '0;
        i_pos_x = 0; i_pos_y = 0; i_pos_z = 0; i_dir_x = 0; i_dir_y = 0; i_dir_z = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        tri_count = '0; idle_pct = 0; taken = 0;
        errors = 0; n_loads = 0; n_rays = 0; n_hits = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: a plain hit, an equal-t duplicate, a triangle through zero,
        // and one at the extremes of the coordinate range
        push_load(0, 0, -8*U, -8*U, 5*U); push_load(0, 1, 8*U, -8*U, 5*U);
        push_load(0, 2, 0, 8*U, 5*U);
        push_load(1, 0, -8*U, -8*U, 5*U); push_load(1, 1, 8*U, -8*U, 5*U);
        push_load(1, 2, 0, 8*U, 5*U);
        push_load(2, 0, -8*U, -8*U, 0); push_load(2, 1, 8*U, -8*U, 0);
        push_load(2, 2, 0, 8*U, 0);
        push_load(3, 0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        push_load(3, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        push_load(3, 2, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_load(1023, 3, 32'h7FFF_FFFF, 32'h8000_0000, -1);  // corner 3: ignored
        for (int i = 0; i < 3; i++) for (int k = 0; k < 3; k++) centre[i][k] = 0;
        write_count(4);
        push_ray(0, 0, U, 0, 0, U);                    // hit, duplicate wins
        push_ray(0, 0, -3*U, 0, 0, U);                 // point at zero drops later hits
        push_ray(0, 0, U, U, 0, 0);                    // parallel
        push_ray(0, 0, U, 0, 0, -U);                   // behind, save a point at zero
        push_ray(0, 0, U, 0, 0, 1);                    // saturated t
        push_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        write_count(0);
        push_ray(0, 0, U, 0, 0, U);                    // nothing searched

        // random phases over a small store
        for (int i = 0; i < 16; i++) add_triangle(i, 0);
        for (int ph = 0; ph < 4; ph++) begin
            cnt = (ph == 0) ? 16 : (ph == 2) ? 1 : $urandom_range(2, 16);
            write_count(cnt);
            idle_pct = phase_idle[ph];
            for (int n = 0; n < 90; n++) begin
                int r;
                r = $urandom_range(99);
                if (r < 20)
                    add_triangle($urandom_range(0, cnt-1), $urandom_range(99) < 10);
                else if (r < 25)
                    push_load($urandom_range(0, 1023), 3, $urandom, $urandom, $urandom);
                else
                    add_ray($urandom_range(0, cnt-1), $urandom_range(99) < 10);
            end
        end

        while (cmd_queue.size() != 0 || pending_hits.size() != 0 || start)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d loads and %0d rays (%0d hits) over counts 0 to 16,",
                 n_loads, n_rays, n_hits);
        $display("with directed edge cases and idle-gap phases; %0d mismatches.", errors);
        if (errors == 0 && pending_hits.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
